// ===== rtl/core/kmc_pkg.sv =====
package kmc_pkg;

	// Default sizes of the stores
	localparam int MAX_POINTS_DEF   = 1024;
	localparam int MAX_DIMS_DEF     = 8;
	localparam int MAX_CLUSTERS_DEF = 8;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_GIVEN_INIT = 3'd4;

	localparam logic [10:0] NUM_POINTS_RST     = 11'd1024;
	localparam logic [3:0]  NUM_DIMS_RST       = 4'd8;
	localparam logic [3:0]  NUM_CLUSTERS_RST   = 4'd8;
	localparam logic [15:0] MAX_ITERATIONS_RST = 16'd200;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_INDEX = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	// Operations broadcast to every cell
	typedef enum logic [1:0] {
		BUS_NOP,
		BUS_CLR,
		BUS_ADD,
		BUS_WR
	} bus_op_t;

	typedef struct packed {
		bus_op_t op;
		logic    inc;
	} bus_ctl_t;

	// Control part of a coordinate travelling down the chain
	typedef struct packed {
		logic valid;
		logic last;
		logic fin;
		logic best_v;
	} tok_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_END,
		ST_CLR,
		ST_STREAM,
		ST_DRAIN,
		ST_DIV_ISSUE,
		ST_DIV_WAIT,
		ST_DIV_WB,
		ST_OUT
	} state_t;

	// Index width, never below one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== rtl/core/kmc_ram.sv =====
module kmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [kmc_pkg::idx_w(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [kmc_pkg::idx_w(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/kmc_div.sv =====
module kmc_div #(
	parameter int SW = 43,
	parameter int NW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [SW-1:0] num,
	input  logic [NW-1:0]        den,
	output logic                 done,
	output logic signed [SW-1:0] quo
);

	localparam int SCW = $clog2(SW + 1);

	logic [SCW-1:0] step_q;
	logic           busy_q;
	logic           done_q;
	logic [SW-1:0]  q_q;
	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  den_q;
	logic           neg_q;
	logic [NW:0]    trial;
	logic           ge;
	logic [NW:0]    diff;

	// One quotient bit a cycle, restoring
	assign trial = {rem_q, q_q[SW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SCW'(SW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[SW-1] ? SW'(-num) : num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[SW-1];
		end else if (busy_q) begin
			q_q   <= {q_q[SW-2:0], ge};
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
		end
	end

	// Truncate toward zero: divide magnitudes, then restore the sign
	assign quo  = neg_q ? -$signed(q_q) : $signed(q_q);
	assign done = done_q;

endmodule

// ===== rtl/core/kmc_cell.sv =====
module kmc_cell #(
	parameter int MAX_DIMS = 8,
	parameter int CELL_ID  = 0,
	parameter int CIW      = 3,
	parameter int DIW      = 3,
	parameter int DSTW     = 69,
	parameter int SW       = 43,
	parameter int NW       = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  kmc_pkg::tok_ctl_t    tin_ctl,
	input  logic signed [31:0]   tin_val,
	input  logic [DIW-1:0]       tin_d,
	input  logic [DSTW-1:0]      tin_dist,
	input  logic [CIW-1:0]       tin_idx,
	output kmc_pkg::tok_ctl_t    tout_ctl,
	output logic signed [31:0]   tout_val,
	output logic [DIW-1:0]       tout_d,
	output logic [DSTW-1:0]      tout_dist,
	output logic [CIW-1:0]       tout_idx,
	input  kmc_pkg::bus_ctl_t    bus_ctl,
	input  logic [CIW-1:0]       bus_c,
	input  logic [DIW-1:0]       bus_d,
	input  logic signed [31:0]   bus_val,
	output logic signed [31:0]   cen_rd,
	output logic signed [SW-1:0] sum_rd,
	output logic [NW-1:0]        cnt_rd
);

	logic signed [31:0]   cen_q [MAX_DIMS];
	logic signed [SW-1:0] sum_q [MAX_DIMS];
	logic [NW-1:0]        cnt_q;

	logic [DIW-1:0]       cen_addr;
	logic signed [31:0]   cen_sel;
	logic signed [32:0]   diff;
	logic [32:0]          mag;
	logic [65:0]          prod;

	kmc_pkg::tok_ctl_t    ctl_s1;
	logic signed [31:0]   val_s1;
	logic [DIW-1:0]       d_s1;
	logic [DSTW-1:0]      dist_s1;
	logic [CIW-1:0]       idx_s1;
	logic [64:0]          sq_s1;

	logic [DSTW-1:0]      acc_q;
	logic [DSTW-1:0]      dnow;
	logic                 win;

	kmc_pkg::tok_ctl_t    ctl_s2;
	logic signed [31:0]   val_s2;
	logic [DIW-1:0]       d_s2;
	logic [DSTW-1:0]      dist_s2;
	logic [CIW-1:0]       idx_s2;

	// Single read address: the travelling coordinate, else the broadcast one
	assign cen_addr = tin_ctl.valid ? tin_d : bus_d;
	assign cen_sel  = cen_q[cen_addr];
	assign cen_rd   = cen_sel;
	assign sum_rd   = sum_q[bus_d];
	assign cnt_rd   = cnt_q;

	// Stage 1: squared difference of one coordinate
	assign diff = $signed({tin_val[31], tin_val}) - $signed({cen_sel[31], cen_sel});
	assign mag  = diff[32] ? (~diff + 33'd1) : diff;
	assign prod = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= tin_ctl;
		end
	end

	always_ff @(posedge clk) begin
		val_s1  <= tin_val;
		d_s1    <= tin_d;
		dist_s1 <= tin_dist;
		idx_s1  <= tin_idx;
		sq_s1   <= prod[64:0];
	end

	// Stage 2: accumulate over the point, compete on its last coordinate
	assign dnow = ((d_s1 == '0) ? '0 : acc_q) + DSTW'(sq_s1);
	assign win  = en && ctl_s1.valid && ctl_s1.last && (!ctl_s1.best_v || dnow < dist_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= '{valid: ctl_s1.valid, last: ctl_s1.last, fin: ctl_s1.fin,
				best_v: ctl_s1.best_v | win};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= dnow;
		end
		val_s2  <= val_s1;
		d_s2    <= d_s1;
		dist_s2 <= win ? dnow : dist_s1;
		idx_s2  <= win ? CIW'(CELL_ID) : idx_s1;
	end

	assign tout_ctl  = ctl_s2;
	assign tout_val  = val_s2;
	assign tout_d    = d_s2;
	assign tout_dist = dist_s2;
	assign tout_idx  = idx_s2;

	// Broadcast operations on centroid, sums and member count
	always_ff @(posedge clk) begin
		unique case (bus_ctl.op)
			kmc_pkg::BUS_CLR: begin
				for (int i = 0; i < MAX_DIMS; i++) begin
					sum_q[i] <= '0;
				end
				cnt_q <= '0;
			end
			kmc_pkg::BUS_ADD: begin
				if (bus_c == CIW'(CELL_ID)) begin
					sum_q[bus_d] <= sum_q[bus_d] + SW'(bus_val);
					if (bus_ctl.inc) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			kmc_pkg::BUS_WR: begin
				if (bus_c == CIW'(CELL_ID)) begin
					cen_q[bus_d] <= bus_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/kmeans_lloyd_clustering_unit.sv =====
// Lloyd k-means engine over signed Q16.16 points.
// Input: an item is taken at a rising edge with start high and busy low.
//   command load coordinate and load initial index leave busy low, so they
//   stream at one item per cycle.
//   command start raises busy until the run is over.
// Configuration: cfg_we / cfg_index / cfg_data, written while busy is low.
// Results: result_valid marks each final centroid coordinate for one cycle,
//   cluster-major, with last on the final one; the receiver cannot stall.
// Sequence of a start, with k clusters, d dimensions and n points: seeding
//   the k centroids; each pass streams the n*d coordinates through the cell
//   chain, drains it, then forms the means in the shared serial divider of
//   width SW = 33+log2(MAX_POINTS); then output of the k*d coordinates.
//   The divider sets the cost of the update step.
// The centroid chain holds one cell per cluster; each cell takes one
//   coordinate a cycle and hands it, with the best distance so far, on.
// Reset clears all control state and the configuration to its defaults;
//   the point store holds no valid contents until loaded.
module kmeans_lloyd_clustering_unit #(
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
	parameter int MAX_DIMS     = kmc_pkg::MAX_DIMS_DEF,
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       command,
	input  logic signed [31:0]               value,
	input  logic                             cfg_we,
	input  logic [kmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kmc_pkg::CFG_W-1:0]        cfg_data,
	output logic                             result_valid,
	output logic signed [31:0]               centroid_value,
	output logic [2:0]                       cluster_index,
	output logic [2:0]                       dim_index,
	output logic [15:0]                      passes_run,
	output logic                             last
);

	localparam int PD   = MAX_POINTS * MAX_DIMS;
	localparam int AW   = kmc_pkg::idx_w(PD);
	localparam int PIW  = kmc_pkg::idx_w(MAX_POINTS);
	localparam int NW   = $clog2(MAX_POINTS + 1);
	localparam int DIW  = kmc_pkg::idx_w(MAX_DIMS);
	localparam int DCW  = $clog2(MAX_DIMS + 1);
	localparam int CIW  = kmc_pkg::idx_w(MAX_CLUSTERS);
	localparam int KW   = $clog2(MAX_CLUSTERS + 1);
	localparam int SW   = 33 + PIW;
	localparam int DSTW = 65 + $clog2(MAX_DIMS + 1);

	// Configuration registers
	logic [10:0] np_q;
	logic [3:0]  ndr_q;
	logic [3:0]  nkr_q;
	logic [15:0] mi_q;
	logic        ug_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q  <= kmc_pkg::NUM_POINTS_RST;
			ndr_q <= kmc_pkg::NUM_DIMS_RST;
			nkr_q <= kmc_pkg::NUM_CLUSTERS_RST;
			mi_q  <= kmc_pkg::MAX_ITERATIONS_RST;
			ug_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmc_pkg::CFG_NUM_POINTS:     np_q  <= cfg_data[10:0];
				kmc_pkg::CFG_NUM_DIMS:       ndr_q <= cfg_data[3:0];
				kmc_pkg::CFG_NUM_CLUSTERS:   nkr_q <= cfg_data[3:0];
				kmc_pkg::CFG_MAX_ITERATIONS: mi_q  <= cfg_data;
				kmc_pkg::CFG_USE_GIVEN_INIT: ug_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the sizes to their legal ranges
	logic [NW-1:0]  n_c;
	logic [DCW-1:0] nd_c;
	logic [KW-1:0]  k_c;

	always_comb begin
		int unsigned np_i;
		int unsigned nd_i;
		int unsigned nk_i;
		np_i = np_q;
		nd_i = ndr_q;
		nk_i = nkr_q;
		if (np_i == 0) np_i = 1;
		if (np_i > MAX_POINTS) np_i = MAX_POINTS;
		if (nd_i == 0) nd_i = 1;
		if (nd_i > MAX_DIMS) nd_i = MAX_DIMS;
		if (nk_i == 0) nk_i = 1;
		if (nk_i > MAX_CLUSTERS) nk_i = MAX_CLUSTERS;
		if (nk_i > np_i) nk_i = np_i;
		n_c  = NW'(np_i);
		nd_c = DCW'(nd_i);
		k_c  = KW'(nk_i);
	end

	kmc_pkg::state_t state_q, state_d;

	logic           acc;
	logic [AW-1:0]  load_pos_q;
	logic [CIW-1:0] idx_pos_q;
	logic [PIW-1:0] init_q [MAX_CLUSTERS];

	logic [NW-1:0]  n_q;
	logic [DCW-1:0] nd_q;
	logic [KW-1:0]  k_q;
	logic [AW-1:0]  tot_m1_q;
	logic [15:0]    passes_q;
	logic           changed_q;
	logic [CIW-1:0] cc_q;
	logic [DIW-1:0] cd_q;
	logic [AW-1:0]  addr_q;
	logic [DIW-1:0] std_q;
	logic signed [31:0] m_q;

	logic           seed_v_s1;
	logic [CIW-1:0] sc_s1;
	logic [DIW-1:0] sd_s1;
	logic           hv_s1;
	logic [DIW-1:0] hd_s1;
	logic           hlast_s1;
	logic           hfin_s1;

	logic signed [31:0] cap_q [MAX_DIMS];
	logic signed [31:0] rep_q [MAX_DIMS];
	logic [CIW-1:0]     rep_c_q;
	logic [DIW-1:0]     rep_d_q;
	logic [DCW-1:0]     rep_left_q;
	logic               fin_q;

	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;
	logic [AW-1:0]      seed_addr;
	logic [PIW-1:0]     seed_raw;
	logic [PIW-1:0]     seed_idx;

	logic               c_end;
	logic               d_end;
	logic               sweep_end;
	logic               changed_next;

	kmc_pkg::bus_ctl_t  bus_ctl;
	logic [CIW-1:0]     bus_c;
	logic [DIW-1:0]     bus_d;
	logic signed [31:0] bus_val;

	logic signed [31:0]   cen_rd_a [MAX_CLUSTERS];
	logic signed [SW-1:0] sum_rd_a [MAX_CLUSTERS];
	logic [NW-1:0]        cnt_rd_a [MAX_CLUSTERS];
	logic signed [31:0]   cen_sel;
	logic signed [SW-1:0] sum_sel;
	logic [NW-1:0]        cnt_sel;

	logic                 div_start;
	logic                 div_done;
	logic signed [SW-1:0] div_quo;

	assign busy = (state_q != kmc_pkg::ST_IDLE);
	assign acc  = start && !busy;

	assign cen_sel = cen_rd_a[cc_q];
	assign sum_sel = sum_rd_a[cc_q];
	assign cnt_sel = cnt_rd_a[cc_q];

	assign d_end     = (DCW'(cd_q) == nd_q - 1'b1);
	assign c_end     = (KW'(cc_q) == k_q - 1'b1);
	assign sweep_end = c_end && d_end;
	assign changed_next = changed_q || (m_q != cen_sel);

	// Seed point: first points or loaded indices, clamped to points in use
	assign seed_raw  = ug_q ? init_q[cc_q] : PIW'(cc_q);
	assign seed_idx  = (NW'(seed_raw) >= n_q) ? PIW'(n_q - 1'b1) : seed_raw;
	assign seed_addr = AW'(seed_idx) * AW'(nd_q) + AW'(cd_q);

	assign ram_we    = acc && (command == kmc_pkg::CMD_LOAD);
	assign ram_raddr = (state_q == kmc_pkg::ST_SEED) ? seed_addr : addr_q;

	kmc_ram #(
		.WIDTH (32),
		.DEPTH (PD)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_pos_q),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and broadcast operation
	always_comb begin
		state_d   = state_q;
		bus_ctl   = '{op: kmc_pkg::BUS_NOP, inc: 1'b0};
		bus_c     = cc_q;
		bus_d     = cd_q;
		bus_val   = m_q;
		div_start = 1'b0;
		unique case (state_q)
			kmc_pkg::ST_IDLE: begin
				if (acc && (command == kmc_pkg::CMD_START)) begin
					state_d = kmc_pkg::ST_SEED;
				end
			end
			kmc_pkg::ST_SEED, kmc_pkg::ST_SEED_END: begin
				if (seed_v_s1) begin
					bus_ctl.op = kmc_pkg::BUS_WR;
					bus_c      = sc_s1;
					bus_d      = sd_s1;
					bus_val    = $signed(ram_rdata);
				end
				if (state_q == kmc_pkg::ST_SEED) begin
					if (sweep_end) state_d = kmc_pkg::ST_SEED_END;
				end else begin
					state_d = (mi_q == '0) ? kmc_pkg::ST_OUT : kmc_pkg::ST_CLR;
				end
			end
			kmc_pkg::ST_CLR: begin
				bus_ctl.op = kmc_pkg::BUS_CLR;
				state_d    = kmc_pkg::ST_STREAM;
			end
			kmc_pkg::ST_STREAM, kmc_pkg::ST_DRAIN: begin
				if (rep_left_q != '0) begin
					bus_ctl.op  = kmc_pkg::BUS_ADD;
					bus_ctl.inc = (rep_d_q == '0);
					bus_c       = rep_c_q;
					bus_d       = rep_d_q;
					bus_val     = rep_q[0];
				end
				if (state_q == kmc_pkg::ST_STREAM) begin
					if (addr_q == tot_m1_q) state_d = kmc_pkg::ST_DRAIN;
				end else if (fin_q && (rep_left_q == '0)) begin
					state_d = kmc_pkg::ST_DIV_ISSUE;
				end
			end
			kmc_pkg::ST_DIV_ISSUE: begin
				if (cnt_sel == '0) begin
					state_d = kmc_pkg::ST_DIV_WB;
				end else begin
					div_start = 1'b1;
					state_d   = kmc_pkg::ST_DIV_WAIT;
				end
			end
			kmc_pkg::ST_DIV_WAIT: begin
				if (div_done) state_d = kmc_pkg::ST_DIV_WB;
			end
			kmc_pkg::ST_DIV_WB: begin
				bus_ctl.op = kmc_pkg::BUS_WR;
				if (!sweep_end) begin
					state_d = kmc_pkg::ST_DIV_ISSUE;
				end else if (changed_next && ({1'b0, passes_q} + 17'd1 < {1'b0, mi_q})) begin
					state_d = kmc_pkg::ST_CLR;
				end else begin
					state_d = kmc_pkg::ST_OUT;
				end
			end
			kmc_pkg::ST_OUT: begin
				if (sweep_end) state_d = kmc_pkg::ST_IDLE;
			end
			default: begin
				state_d = kmc_pkg::ST_IDLE;
			end
		endcase
	end

	// Load positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			idx_pos_q  <= '0;
		end else if (acc) begin
			case (command)
				kmc_pkg::CMD_LOAD: begin
					load_pos_q <= (load_pos_q == AW'(PD - 1)) ? '0 : load_pos_q + 1'b1;
				end
				kmc_pkg::CMD_INDEX: begin
					idx_pos_q <= (idx_pos_q == CIW'(MAX_CLUSTERS - 1)) ? '0 : idx_pos_q + 1'b1;
				end
				kmc_pkg::CMD_START: begin
					load_pos_q <= '0;
					idx_pos_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Initial index store, out-of-range indices clamp to the last point
	always_ff @(posedge clk) begin
		if (acc && (command == kmc_pkg::CMD_INDEX)) begin
			init_q[idx_pos_q] <= (value < 0 || value >= MAX_POINTS) ?
				PIW'(MAX_POINTS - 1) : PIW'(value);
		end
	end

	// Sweep counters, pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			nd_q      <= '0;
			k_q       <= '0;
			tot_m1_q  <= '0;
			passes_q  <= '0;
			changed_q <= 1'b0;
			cc_q      <= '0;
			cd_q      <= '0;
			addr_q    <= '0;
			std_q     <= '0;
			m_q       <= '0;
		end else begin
			case (state_q)
				kmc_pkg::ST_IDLE: begin
					if (acc && (command == kmc_pkg::CMD_START)) begin
						n_q      <= n_c;
						nd_q     <= nd_c;
						k_q      <= k_c;
						tot_m1_q <= AW'(n_c * nd_c - 1);
						passes_q <= '0;
						cc_q     <= '0;
						cd_q     <= '0;
					end
				end
				kmc_pkg::ST_SEED, kmc_pkg::ST_DIV_WB, kmc_pkg::ST_OUT: begin
					if (d_end) begin
						cd_q <= '0;
						cc_q <= c_end ? '0 : cc_q + 1'b1;
					end else begin
						cd_q <= cd_q + 1'b1;
					end
					if (state_q == kmc_pkg::ST_DIV_WB) begin
						changed_q <= changed_next;
						if (sweep_end) passes_q <= passes_q + 1'b1;
					end
				end
				kmc_pkg::ST_CLR: begin
					addr_q    <= '0;
					std_q     <= '0;
					changed_q <= 1'b0;
				end
				kmc_pkg::ST_STREAM: begin
					addr_q <= addr_q + 1'b1;
					std_q  <= (DCW'(std_q) == nd_q - 1'b1) ? '0 : std_q + 1'b1;
				end
				kmc_pkg::ST_DIV_ISSUE: begin
					if (cnt_sel == '0) m_q <= '0;
				end
				kmc_pkg::ST_DIV_WAIT: begin
					if (div_done) m_q <= div_quo[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Seed write-back and chain head, aligned to the read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_v_s1 <= 1'b0;
			hv_s1     <= 1'b0;
		end else begin
			seed_v_s1 <= (state_q == kmc_pkg::ST_SEED);
			hv_s1     <= (state_q == kmc_pkg::ST_STREAM);
		end
	end

	always_ff @(posedge clk) begin
		sc_s1    <= cc_q;
		sd_s1    <= cd_q;
		hd_s1    <= std_q;
		hlast_s1 <= (DCW'(std_q) == nd_q - 1'b1);
		hfin_s1  <= (addr_q == tot_m1_q);
	end

	// Cell chain
	kmc_pkg::tok_ctl_t  lk_ctl  [MAX_CLUSTERS+1];
	logic signed [31:0] lk_val  [MAX_CLUSTERS+1];
	logic [DIW-1:0]     lk_d    [MAX_CLUSTERS+1];
	logic [DSTW-1:0]    lk_dist [MAX_CLUSTERS+1];
	logic [CIW-1:0]     lk_idx  [MAX_CLUSTERS+1];

	assign lk_ctl[0]  = '{valid: hv_s1, last: hlast_s1, fin: hfin_s1, best_v: 1'b0};
	assign lk_val[0]  = $signed(ram_rdata);
	assign lk_d[0]    = hd_s1;
	assign lk_dist[0] = '0;
	assign lk_idx[0]  = '0;

	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		kmc_cell #(
			.MAX_DIMS (MAX_DIMS),
			.CELL_ID  (i),
			.CIW      (CIW),
			.DIW      (DIW),
			.DSTW     (DSTW),
			.SW       (SW),
			.NW       (NW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (KW'(i) < k_q),
			.tin_ctl   (lk_ctl[i]),
			.tin_val   (lk_val[i]),
			.tin_d     (lk_d[i]),
			.tin_dist  (lk_dist[i]),
			.tin_idx   (lk_idx[i]),
			.tout_ctl  (lk_ctl[i+1]),
			.tout_val  (lk_val[i+1]),
			.tout_d    (lk_d[i+1]),
			.tout_dist (lk_dist[i+1]),
			.tout_idx  (lk_idx[i+1]),
			.bus_ctl   (bus_ctl),
			.bus_c     (bus_c),
			.bus_d     (bus_d),
			.bus_val   (bus_val),
			.cen_rd    (cen_rd_a[i]),
			.sum_rd    (sum_rd_a[i]),
			.cnt_rd    (cnt_rd_a[i])
		);
	end

	// Chain tail: gather a point, then replay it into the winner's sums
	always_ff @(posedge clk) begin
		if (lk_ctl[MAX_CLUSTERS].valid) begin
			cap_q[lk_d[MAX_CLUSTERS]] <= lk_val[MAX_CLUSTERS];
		end
		if (lk_ctl[MAX_CLUSTERS].valid && lk_ctl[MAX_CLUSTERS].last) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				rep_q[i] <= (DIW'(i) == lk_d[MAX_CLUSTERS]) ? lk_val[MAX_CLUSTERS] : cap_q[i];
			end
			rep_c_q <= lk_idx[MAX_CLUSTERS];
			rep_d_q <= '0;
		end else if (rep_left_q != '0) begin
			for (int i = 0; i < MAX_DIMS - 1; i++) begin
				rep_q[i] <= rep_q[i+1];
			end
			rep_d_q <= rep_d_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_left_q <= '0;
			fin_q      <= 1'b0;
		end else begin
			if (lk_ctl[MAX_CLUSTERS].valid && lk_ctl[MAX_CLUSTERS].last) begin
				rep_left_q <= nd_q;
			end else if (rep_left_q != '0) begin
				rep_left_q <= rep_left_q - 1'b1;
			end
			if (state_q == kmc_pkg::ST_CLR) begin
				fin_q <= 1'b0;
			end else if (lk_ctl[MAX_CLUSTERS].valid && lk_ctl[MAX_CLUSTERS].fin) begin
				fin_q <= 1'b1;
			end
		end
	end

	// Shared divider for the cluster means
	kmc_div #(
		.SW (SW),
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_sel),
		.den    (cnt_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == kmc_pkg::ST_OUT);
		end
	end

	always_ff @(posedge clk) begin
		centroid_value <= cen_sel;
		cluster_index  <= 3'(cc_q);
		dim_index      <= 3'(cd_q);
		passes_run     <= passes_q;
		last           <= sweep_end;
	end

	// Checks
	a_idle_no_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kmc_pkg::ST_IDLE) |-> (rep_left_q == '0))
		else $error("replay still running while idle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result after the final coordinate");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == kmc_pkg::ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == kmc_pkg::CMD_START)) |=> busy)
		else $error("start transfer did not raise busy");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int NPTS  = kmc_pkg::MAX_POINTS_DEF;
	localparam int NDIM  = kmc_pkg::MAX_DIMS_DEF;
	localparam int NCLU  = kmc_pkg::MAX_CLUSTERS_DEF;
	localparam int DEPTH = NPTS * NDIM;
	localparam int QUIET_LIMIT = 400000;

	typedef struct {
		logic signed [31:0] coord;
		logic [2:0]         clu;
		logic [2:0]         dim;
		logic [15:0]        passes;
		logic               fin;
	} centroid_res_t;

	// Lloyd predictor and the queue of centroid coordinates it expects
	class kmeans_scoreboard;
		longint         pts[DEPTH];
		longint         cen[NCLU*NDIM];
		int unsigned    seed_idx[NCLU];
		int unsigned    load_pos, idx_pos;
		logic [10:0]    reg_np;
		logic [3:0]     reg_nd, reg_nk;
		logic [15:0]    reg_mi;
		logic           reg_ugi;
		centroid_res_t  expected_q[$];
		int             mismatches, checked;

		function new();
			load_pos = 0; idx_pos = 0;
			reg_np = kmc_pkg::NUM_POINTS_RST;
			reg_nd = kmc_pkg::NUM_DIMS_RST;
			reg_nk = kmc_pkg::NUM_CLUSTERS_RST;
			reg_mi = kmc_pkg::MAX_ITERATIONS_RST; reg_ugi = 1'b0;
			mismatches = 0; checked = 0;
		endfunction

		function void write_reg(logic [kmc_pkg::CFG_IDX_W-1:0] idx,
				logic [kmc_pkg::CFG_W-1:0] data);
			case (idx)
				kmc_pkg::CFG_NUM_POINTS:     reg_np  = data[10:0];
				kmc_pkg::CFG_NUM_DIMS:       reg_nd  = data[3:0];
				kmc_pkg::CFG_NUM_CLUSTERS:   reg_nk  = data[3:0];
				kmc_pkg::CFG_MAX_ITERATIONS: reg_mi  = data[15:0];
				kmc_pkg::CFG_USE_GIVEN_INIT: reg_ugi = data[0];
				default: ;
			endcase
		endfunction

		function logic [127:0] dist2(int unsigned p, int unsigned c, int unsigned nd);
			logic [127:0] acc;
			longint       diff;
			logic [63:0]  m;
			acc = '0;
			for (int d = 0; d < nd; d++) begin
				diff = pts[p*nd+d] - cen[c*NDIM+d];
				m = (diff < 0) ? 64'(-diff) : 64'(diff);
				acc += 128'(m) * 128'(m);
			end
			return acc;
		endfunction

		function void cluster_run();
			int unsigned  n, nd, k, idx, best, passes;
			longint       sums[NCLU*NDIM];
			int unsigned  cnt[NCLU];
			logic [127:0] bd, dd;
			longint       mean;
			bit           moved;
			centroid_res_t r;
			n  = (reg_np == 0) ? 1 : (reg_np > NPTS) ? NPTS : reg_np;
			nd = (reg_nd == 0) ? 1 : (reg_nd > NDIM) ? NDIM : reg_nd;
			k  = (reg_nk == 0) ? 1 : (reg_nk > NCLU) ? NCLU : reg_nk;
			if (k > n) k = n;
			// seed the centroids
			for (int c = 0; c < k; c++) begin
				idx = c;
				if (reg_ugi) begin
					idx = seed_idx[c];
					if (idx >= n) idx = n - 1;
				end
				for (int d = 0; d < nd; d++) cen[c*NDIM+d] = pts[idx*nd+d];
			end
			passes = 0;
			moved = 1'b1;
			while (moved && passes < reg_mi) begin
				foreach (sums[i]) sums[i] = 0;
				foreach (cnt[i]) cnt[i] = 0;
				for (int p = 0; p < n; p++) begin
					best = 0;
					bd = dist2(p, 0, nd);
					for (int c = 1; c < k; c++) begin
						dd = dist2(p, c, nd);
						if (dd < bd) begin
							best = c; bd = dd;
						end
					end
					for (int d = 0; d < nd; d++) sums[best*NDIM+d] += pts[p*nd+d];
					cnt[best]++;
				end
				moved = 1'b0;
				for (int c = 0; c < k; c++)
					for (int d = 0; d < nd; d++) begin
						mean = cnt[c] ? sums[c*NDIM+d] / longint'(cnt[c]) : 0;
						if (mean != cen[c*NDIM+d]) moved = 1'b1;
						cen[c*NDIM+d] = mean;
					end
				passes++;
			end
			for (int c = 0; c < k; c++)
				for (int d = 0; d < nd; d++) begin
					r.coord  = cen[c*NDIM+d][31:0];
					r.clu    = c[2:0];
					r.dim    = d[2:0];
					r.passes = passes[15:0];
					r.fin    = (c == k-1 && d == nd-1);
					expected_q.push_back(r);
				end
			load_pos = 0;
			idx_pos  = 0;
		endfunction

		function void note_input(logic [1:0] cmd, logic signed [31:0] v);
			case (cmd)
				kmc_pkg::CMD_LOAD: begin
					pts[load_pos] = v;
					load_pos = (load_pos + 1) % DEPTH;
				end
				kmc_pkg::CMD_INDEX: begin
					seed_idx[idx_pos] = (v < 0 || v >= NPTS) ? NPTS - 1 : v;
					idx_pos = (idx_pos + 1) % NCLU;
				end
				kmc_pkg::CMD_START: cluster_run();
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [31:0] cv, logic [2:0] ci, logic [2:0] di,
				logic [15:0] pr, logic lst);
			centroid_res_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h cluster %0d dim %0d", cv, ci, di);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (cv !== e.coord || ci !== e.clu || di !== e.dim || pr !== e.passes ||
					lst !== e.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp val %h c %0d d %0d passes %0d last %b | got val %h c %0d d %0d passes %0d last %b",
						e.coord, e.clu, e.dim, e.passes, e.fin, cv, ci, di, pr, lst);
			end
		endfunction
	endclass

	logic                          clk, arst_n;
	logic                          start, busy;
	logic [1:0]                    command;
	logic signed [31:0]            value;
	logic                          cfg_we;
	logic [kmc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kmc_pkg::CFG_W-1:0]     cfg_data;
	logic                          result_valid;
	logic signed [31:0]            centroid_value;
	logic [2:0]                    cluster_index, dim_index;
	logic [15:0]                   passes_run;
	logic                          last;

	kmeans_scoreboard sb;
	int  quiet_cycles, item_count, run_count, burst_left;
	bit  no_gaps;

	kmeans_lloyd_clustering_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .value(value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .centroid_value(centroid_value),
		.cluster_index(cluster_index), .dim_index(dim_index),
		.passes_run(passes_run), .last(last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Observe transfers in both directions and guard against a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_input(command, value);
			end
			if (result_valid) begin
				sb.check_result(centroid_value, cluster_index, dim_index, passes_run, last);
			end
			if ((start && !busy) || result_valid) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Offer one command, idling between bursts
	task automatic send(logic [1:0] c, logic [31:0] v);
		int g;
		if (burst_left <= 0) begin
			g = no_gaps ? 0 : $urandom_range(0, 5);
			if (g > 0) begin
				start <= 1'b0;
				repeat (g) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		start   <= 1'b1;
		command <= c;
		value   <= v;
		do @(posedge clk); while (busy);
		burst_left--;
		item_count++;
	endtask

	// Hold until the block is idle and every centroid has arrived
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (busy || sb.expected_q.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(int np, int nd, int nk, int mi, int ugi);
		logic [kmc_pkg::CFG_IDX_W-1:0] idx[5];
		int                            val[5];
		idx = '{kmc_pkg::CFG_NUM_POINTS, kmc_pkg::CFG_NUM_DIMS, kmc_pkg::CFG_NUM_CLUSTERS,
			kmc_pkg::CFG_MAX_ITERATIONS, kmc_pkg::CFG_USE_GIVEN_INIT};
		val = '{np, nd, nk, mi, ugi};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i][kmc_pkg::CFG_W-1:0];
			sb.write_reg(idx[i], val[i][kmc_pkg::CFG_W-1:0]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] point_val(int mode, int unsigned p);
		logic [31:0] x[4];
		x = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
		case (mode)
			0: return $urandom;
			1: return 32'((p % 3) * 32'h00100000) - 32'h00100000 + $urandom_range(0, 255);
			2: return x[$urandom_range(0, 3)];
			default: return ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [31:0] seed_val(int unsigned n);
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(n, NPTS - 1));
			1: return $urandom | 32'h80000000;
			2: return 32'($urandom_range(NPTS, 20000));
			3: return $urandom;
			default: return 32'($urandom_range(0, n - 1));
		endcase
	endfunction

	// One clustering job: registers, points, seeds, start, drain
	task automatic run_case(int np, int nd, int nk, int mi, int ugi, int mode,
			int extra_idx, bit noise);
		int unsigned n, d, k;
		write_regs(np, nd, nk, mi, ugi);
		n = (np[10:0] == 0) ? 1 : (np[10:0] > NPTS) ? NPTS : np[10:0];
		d = (nd[3:0] == 0) ? 1 : (nd[3:0] > NDIM) ? NDIM : nd[3:0];
		k = (nk[3:0] == 0) ? 1 : (nk[3:0] > NCLU) ? NCLU : nk[3:0];
		if (k > n) k = n;
		for (int unsigned i = 0; i < n * d; i++) begin
			if (noise && $urandom_range(0, 7) == 0) send(2'd3, $urandom);
			send(kmc_pkg::CMD_LOAD, point_val(mode, i / d));
		end
		if (ugi[0])
			for (int j = 0; j < k + extra_idx; j++) send(kmc_pkg::CMD_INDEX, seed_val(n));
		send(kmc_pkg::CMD_START, $urandom);
		wait_idle();
		run_count++;
	endtask

	initial begin
		int np, nd, nk, mi;
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0; command <= kmc_pkg::CMD_LOAD; value <= '0;
		cfg_we <= 1'b0; cfg_index <= kmc_pkg::CFG_NUM_POINTS; cfg_data <= '0;
		quiet_cycles = 0; item_count = 0; run_count = 0; burst_left = 0;
		no_gaps = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero passes, extremes, ties, clamped registers and seeds
		run_case(2, 1, 2, 0, 0, 2, 0, 1'b0);
		run_case(3, 2, 2, 65535, 1, 2, 0, 1'b1);
		run_case(0, 0, 0, 1, 0, 0, 0, 1'b0);
		run_case(3, 15, 15, 3, 1, 3, 9, 1'b1);
		run_case(4, 1, 4, 5, 1, 3, 0, 1'b0);

		// random jobs, mostly small so the divider passes stay short
		while (item_count < 220) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 17 : $urandom_range(1, 16);
			nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			nk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			case ($urandom_range(0, 5))
				0: mi = 0;
				1: mi = 1;
				2: mi = 65535;
				default: mi = $urandom_range(2, 30);
			endcase
			run_case(np, nd, nk, mi, $urandom_range(0, 1), $urandom_range(0, 3),
				$urandom_range(0, 10), $urandom_range(0, 1));
		end

		// a longer one-dimensional job with more points than the random ones
		no_gaps = 1'b0;
		run_case(40, 1, 2, 4, 1, 0, 0, 1'b0);

		wait_idle();
		repeat (50) @(posedge clk);
		$display("ran %0d clustering jobs from %0d commands, %0d centroid coordinates checked",
			run_count, item_count, sb.checked);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/kmc_pkg.sv
rtl/core/kmc_ram.sv
rtl/core/kmc_div.sv
rtl/core/kmc_cell.sv
rtl/core/kmeans_lloyd_clustering_unit.sv
test/tb_top.sv
